[design/tbtk_pkg.sv]
// Shared constants, codes and types for the twelve-bit top-k and history block.
`timescale 1ns / 1ps

package tbtk_pkg;

	// Store geometry.
	localparam int ENTRY_COUNT = 32;
	localparam int SAMPLE_BITS = 12;
	localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

	// Command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Byte masks used when unpacking a triple.
	localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
	localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

	// Operation codes on the input channel.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_DUMP = 1'b1;

	// Section codes on the output channel.
	localparam logic SEC_SORTED  = 1'b0;
	localparam logic SEC_HISTORY = 1'b1;

	// Position of the next byte within a triple.
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} byte_phase_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE      = 2'd0,
		BK_SORT      = 2'd1,
		BK_RING_ADDR = 2'd2,
		BK_RING_DATA = 2'd3
	} back_state_t;

	// One classified command.
	typedef struct packed {
		logic                   is_dump;
		logic [SAMPLE_BITS-1:0] value;
	} queue_cmd_t;

	// Write side of the queue.
	typedef struct packed {
		logic       valid;
		queue_cmd_t cmd;
	} queue_wr_t;

	// Read side of the queue.
	typedef struct packed {
		logic       valid;
		queue_cmd_t cmd;
	} queue_head_t;

	// Status returned to the front end.
	typedef struct packed {
		logic full;
	} queue_status_t;

endpackage

[design/tbtk_in_if.sv]
// Input channel: one byte push or dump request per beat.
`timescale 1ns / 1ps

interface tbtk_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source(output valid, output operation, output data_byte, input ready);
	modport sink(input valid, input operation, input data_byte, output ready);
endinterface

[design/tbtk_out_if.sv]
// Output channel: one dumped value per beat.
`timescale 1ns / 1ps

interface tbtk_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample_value;
	logic        section;
	logic        last_of_run;

	modport source(output valid, output sample_value, output section, output last_of_run,
		input ready);
	modport sink(input valid, input sample_value, input section, input last_of_run,
		output ready);
endinterface

[design/tbtk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tbtk_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/tbtk_front.sv]
// Front end: accepts input beats, unpacks 12-bit values and issues commands.
`timescale 1ns / 1ps

module tbtk_front import tbtk_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tbtk_in_if.sink       req,
	input  queue_status_t q_status,
	output queue_wr_t     q_wr
);

	byte_phase_t phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [3:0]  nib_q, nib_d;
	logic        accept;

	// Take a beat whenever the queue can hold what it may produce.
	assign req.ready = !q_status.full;
	assign accept    = req.valid && req.ready;

	// Classify the beat and assemble values from the byte triple.
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		nib_d     = nib_q;
		q_wr      = '0;
		if (accept) begin
			if (req.operation == OP_DUMP) begin
				q_wr.valid       = 1'b1;
				q_wr.cmd.is_dump = 1'b1;
			end else begin
				case (phase_q)
					PH_SECOND: begin
						q_wr.valid     = 1'b1;
						q_wr.cmd.value = {held_q, 4'((req.data_byte & HI_NIBBLE_MASK) >> 4)};
						nib_d          = 4'(req.data_byte & LO_NIBBLE_MASK);
						phase_d        = PH_THIRD;
					end
					PH_THIRD: begin
						q_wr.valid     = 1'b1;
						q_wr.cmd.value = {nib_q, req.data_byte};
						phase_d        = PH_FIRST;
					end
					default: begin
						held_d  = req.data_byte;
						phase_d = PH_SECOND;
					end
				endcase
			end
		end
	end

	// Unpacking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= '0;
			nib_q   <= '0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
			nib_q   <= nib_d;
		end
	end

endmodule

[design/tbtk_queue.sv]
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module tbtk_queue import tbtk_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_wr_t     q_wr,
	input  logic          pop,
	output queue_status_t q_status,
	output queue_head_t   head
);

	queue_cmd_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push, do_pop;

	assign q_status.full = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid    = (fill_q != '0);
	assign head.cmd      = entry_q[rd_ptr_q];
	assign do_push       = q_wr.valid && !q_status.full;
	assign do_pop        = pop && head.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[design/tbtk_back.sv]
// Back end: shift-insert sorted store, history ring and dump sequencer.
`timescale 1ns / 1ps

module tbtk_back import tbtk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	tbtk_out_if.source  rsp
);

	back_state_t            state_q, state_d;
	logic [SAMPLE_BITS-1:0] sorted_q [ENTRY_COUNT];
	logic [SAMPLE_BITS-1:0] sorted_ext [ENTRY_COUNT+1];
	logic [SAMPLE_BITS-1:0] sorted_next [ENTRY_COUNT];
	logic [ENTRY_COUNT:0]   gt;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       sort_idx_q;
	logic [IDX_W-1:0]       ring_i_q;
	logic [IDX_W:0]         ring_sum;
	logic [IDX_W:0]         ring_wrap;
	logic [IDX_W-1:0]       ring_addr;
	logic [SAMPLE_BITS-1:0] ring_data;
	logic                   ring_last;
	logic                   sorted_ok;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_value_q;
	logic                   out_sec_q;
	logic                   out_last_q;
	logic                   out_free;

	logic                   ins_en;
	logic                   sort_start;
	logic                   sort_adv;
	logic                   ring_clr;
	logic                   ring_adv;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] out_value_d;
	logic                   out_sec_d;
	logic                   out_last_d;

	assign rsp.valid        = out_valid_q;
	assign rsp.sample_value = out_value_q;
	assign rsp.section      = out_sec_q;
	assign rsp.last_of_run  = out_last_q;
	assign out_free         = !out_valid_q || rsp.ready;

	// Compare the incoming value against every entry; the hits form a prefix.
	always_comb begin
		for (int p = 0; p < ENTRY_COUNT; p++) begin
			sorted_ext[p] = sorted_q[p];
			gt[p]         = head.cmd.value > sorted_q[p];
		end
		sorted_ext[ENTRY_COUNT] = '0;
		gt[ENTRY_COUNT]         = 1'b0;
		for (int p = 0; p < ENTRY_COUNT; p++) begin
			if (gt[p+1]) begin
				sorted_next[p] = sorted_ext[p+1];
			end else if (gt[p]) begin
				sorted_next[p] = head.cmd.value;
			end else begin
				sorted_next[p] = sorted_q[p];
			end
		end
	end

	// Ring address for the current history result, oldest first.
	always_comb begin
		ring_sum  = {1'b0, head_q} + {1'b0, ring_i_q};
		ring_wrap = ring_sum - (IDX_W+1)'(ENTRY_COUNT);
		if (count_q != CNT_W'(ENTRY_COUNT)) begin
			ring_addr = ring_i_q;
		end else if (ring_sum >= (IDX_W+1)'(ENTRY_COUNT)) begin
			ring_addr = ring_wrap[IDX_W-1:0];
		end else begin
			ring_addr = ring_sum[IDX_W-1:0];
		end
		ring_last = (CNT_W'(ring_i_q) == count_q - CNT_W'(1));
	end

	tbtk_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(ENTRY_COUNT)
	) u_ring (
		.clk     (clk),
		.wr_en   (ins_en),
		.wr_addr (head_q),
		.wr_data (head.cmd.value),
		.rd_addr (ring_addr),
		.rd_data (ring_data)
	);

	// Sequencer: next state and control.
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		ins_en      = 1'b0;
		sort_start  = 1'b0;
		sort_adv    = 1'b0;
		ring_clr    = 1'b0;
		ring_adv    = 1'b0;
		out_load    = 1'b0;
		out_value_d = sorted_q[sort_idx_q];
		out_sec_d   = SEC_SORTED;
		out_last_d  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (!head.cmd.is_dump) begin
						ins_en = 1'b1;
					end else if (count_q != '0) begin
						sort_start = 1'b1;
						state_d    = BK_SORT;
					end
				end
			end
			BK_SORT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (sort_idx_q == IDX_W'(ENTRY_COUNT - 1)) begin
						ring_clr = 1'b1;
						state_d  = BK_RING_ADDR;
					end else begin
						sort_adv = 1'b1;
					end
				end
			end
			BK_RING_ADDR: begin
				state_d = BK_RING_DATA;
			end
			BK_RING_DATA: begin
				out_value_d = ring_data;
				out_sec_d   = SEC_HISTORY;
				out_last_d  = ring_last;
				if (out_free) begin
					out_load = 1'b1;
					if (ring_last) begin
						state_d = BK_IDLE;
					end else begin
						ring_adv = 1'b1;
						state_d  = BK_RING_ADDR;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Sorted store, ring pointer, count and sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			sort_idx_q <= '0;
			ring_i_q   <= '0;
			for (int p = 0; p < ENTRY_COUNT; p++) begin
				sorted_q[p] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ins_en) begin
				for (int p = 0; p < ENTRY_COUNT; p++) begin
					sorted_q[p] <= sorted_next[p];
				end
				head_q <= (head_q == IDX_W'(ENTRY_COUNT - 1)) ? '0 : head_q + 1'b1;
				if (count_q != CNT_W'(ENTRY_COUNT)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (sort_start) begin
				sort_idx_q <= IDX_W'(CNT_W'(ENTRY_COUNT) - count_q);
			end else if (sort_adv) begin
				sort_idx_q <= sort_idx_q + 1'b1;
			end
			if (ring_clr) begin
				ring_i_q <= '0;
			end else if (ring_adv) begin
				ring_i_q <= ring_i_q + 1'b1;
			end
		end
	end

	// Output register: holds a beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= out_value_d;
			out_sec_q   <= out_sec_d;
			out_last_q  <= out_last_d;
		end
	end

	// The store must stay in ascending order.
	always_comb begin
		sorted_ok = 1'b1;
		for (int p = 1; p < ENTRY_COUNT; p++) begin
			if (sorted_q[p-1] > sorted_q[p]) begin
				sorted_ok = 1'b0;
			end
		end
	end

	a_sorted_order: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_ok)
		else $error("sorted store lost ascending order");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRY_COUNT))
		else $error("value count above store depth");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> (count_q != '0))
		else $error("dump running with no values kept");

	a_ring_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RING_ADDR || state_q == BK_RING_DATA) |->
		(CNT_W'(ring_i_q) < count_q))
		else $error("history index beyond kept values");

	a_last_ends_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == BK_IDLE))
		else $error("flagged final beat did not end the dump");

endmodule

[design/twelve_bit_top_k_and_history.sv]
// Top level of the twelve-bit top-k and recent-history block.
`timescale 1ns / 1ps

// Bytes enter on req, three bytes packing two big-endian 12-bit values; a
// beat with operation set is a dump request. The front end takes one beat per
// cycle while its four-entry command queue has room. The back end retires one
// completed value per cycle while no dump is running: it writes the value into
// a 32-entry history ring memory and inserts it into a 32-entry ascending store
// of the largest values through a shift-insert register chain. A dump of
// n = min(values seen, 32) returns, on rsp, n sorted values at one per cycle
// while the sink is ready, and then n history values oldest first, each read
// through the registered read port of the ring memory; later commands wait in
// the queue until it finishes. The final beat of a dump carries last_of_run. A
// dump with no values seen returns nothing, and a pending partial triple is
// left pending. No clearing pass runs after reset.
module twelve_bit_top_k_and_history import tbtk_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tbtk_in_if.sink    req,
	tbtk_out_if.source rsp
);

	queue_wr_t     q_wr;
	queue_status_t q_status;
	queue_head_t   q_head;
	logic          q_pop;

	tbtk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_status (q_status),
		.q_wr     (q_wr)
	);

	tbtk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_wr     (q_wr),
		.pop      (q_pop),
		.q_status (q_status),
		.head     (q_head)
	);

	tbtk_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.rsp    (rsp)
	);

endmodule
